@@ sv/small_language_lexer_defines.svh @@
// Assertion macros shared by the lexer RTL.
// Depends on nothing; included by the top level.
`ifndef SMALL_LANGUAGE_LEXER_DEFINES_SVH
`define SMALL_LANGUAGE_LEXER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SLX_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define SLX_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/slx_pkg.sv @@
// Shared types, constants and character tables of the lexer.
// Depends on nothing; imported by every lexer module.
package slx_pkg;

	localparam int POS_WIDTH = 24;
	localparam int OUT_POS_W = 24;
	localparam int LEN_W     = 24;
	localparam int VAL_W     = 31;
	localparam int KW_W      = 40;
	localparam int KW_CHARS  = 5;
	localparam int MAX_TOKS  = 3;
	localparam int CNT_W     = $clog2(MAX_TOKS + 1);
	localparam int QDEPTH    = 2;

	localparam logic [LEN_W-1:0] LEN_MAX = '1;
	localparam logic [VAL_W-1:0] NUM_MAX = '1;

	// token kinds
	localparam logic [3:0] KIND_PUNC  = 4'd0;
	localparam logic [3:0] KIND_NUM   = 4'd1;
	localparam logic [3:0] KIND_IDENT = 4'd2;
	localparam logic [3:0] KIND_WHILE = 4'd3;
	localparam logic [3:0] KIND_FOR   = 4'd4;
	localparam logic [3:0] KIND_IF    = 4'd5;
	localparam logic [3:0] KIND_ELSE  = 4'd6;
	localparam logic [3:0] KIND_END   = 4'd7;
	localparam logic [3:0] KIND_ERROR = 4'd8;

	// punctuator codes: two-character forms first, then single ones
	localparam logic [4:0] P_LE     = 5'd0;
	localparam logic [4:0] P_GE     = 5'd1;
	localparam logic [4:0] P_EQEQ   = 5'd2;
	localparam logic [4:0] P_NE     = 5'd3;
	localparam logic [4:0] P_ANDAND = 5'd4;
	localparam logic [4:0] P_OROR   = 5'd5;
	localparam logic [4:0] P_LBLB   = 5'd6;
	localparam logic [4:0] P_RBRB   = 5'd7;
	localparam logic [4:0] P_INC    = 5'd8;
	localparam logic [4:0] P_DEC    = 5'd9;
	localparam logic [4:0] P_LBRK   = 5'd10;
	localparam logic [4:0] P_RBRK   = 5'd11;
	localparam logic [4:0] P_LPAR   = 5'd12;
	localparam logic [4:0] P_RPAR   = 5'd13;
	localparam logic [4:0] P_LBRC   = 5'd14;
	localparam logic [4:0] P_RBRC   = 5'd15;
	localparam logic [4:0] P_STAR   = 5'd16;
	localparam logic [4:0] P_SLASH  = 5'd17;
	localparam logic [4:0] P_PLUS   = 5'd18;
	localparam logic [4:0] P_MINUS  = 5'd19;
	localparam logic [4:0] P_PCT    = 5'd20;
	localparam logic [4:0] P_ASSIGN = 5'd21;
	localparam logic [4:0] P_SEMI   = 5'd22;
	localparam logic [4:0] P_LT     = 5'd23;
	localparam logic [4:0] P_GT     = 5'd24;
	localparam logic [4:0] P_AMP    = 5'd25;
	localparam logic [4:0] P_BAR    = 5'd26;
	localparam logic [4:0] P_COMMA  = 5'd27;

	// keyword spellings, right aligned in the prefix register
	localparam logic [KW_W-1:0] KW_WHILE = 40'h7768696C65;
	localparam logic [KW_W-1:0] KW_FOR   = 40'h0000666F72;
	localparam logic [KW_W-1:0] KW_IF    = 40'h0000006966;
	localparam logic [KW_W-1:0] KW_ELSE  = 40'h00656C7365;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_NUM,
		MODE_IDENT,
		MODE_PUNC,
		MODE_DISCARD
	} lex_mode_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       is_last;
	} char_beat_t;

	typedef struct packed {
		logic [3:0]           kind;
		logic [4:0]           punc_code;
		logic [VAL_W-1:0]     value;
		logic                 overflow;
		logic [OUT_POS_W-1:0] start_pos;
		logic [LEN_W-1:0]     tok_len;
		logic                 last_of_run;
	} tok_beat_t;

	typedef struct packed {
		logic [3:0]           kind;
		logic [4:0]           punc_code;
		logic [VAL_W-1:0]     value;
		logic                 overflow;
		logic [OUT_POS_W-1:0] start_pos;
		logic [LEN_W-1:0]     tok_len;
	} tok_t;

	// all tokens raised by one character, cnt from 1 to MAX_TOKS
	typedef struct packed {
		logic [CNT_W-1:0]          cnt;
		tok_t [MAX_TOKS-1:0]       tok;
	} bundle_t;

	typedef struct packed {
		logic full;
		logic vld;
	} q_stat_t;

	typedef struct packed {
		logic       hit;
		logic [4:0] code;
	} punc_hit_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == " ") || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
	endfunction

	function automatic logic is_word(input logic [7:0] c);
		return is_alpha(c) || is_digit(c) || (c == "_");
	endfunction

	function automatic logic opens_pair(input logic [7:0] c);
		logic r;
		r = 1'b0;
		unique case (c) inside
			"<", ">", "=", "!", "&", "|", "[", "]", "+", "-": r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	// two-character punctuator lookup on held char a and new char b
	function automatic punc_hit_t pair_match(input logic [7:0] a, input logic [7:0] b);
		punc_hit_t r;
		r.hit  = 1'b0;
		r.code = P_LE;
		unique case (a)
			"<": begin r.hit = (b == "="); r.code = P_LE;     end
			">": begin r.hit = (b == "="); r.code = P_GE;     end
			"=": begin r.hit = (b == "="); r.code = P_EQEQ;   end
			"!": begin r.hit = (b == "="); r.code = P_NE;     end
			"&": begin r.hit = (b == "&"); r.code = P_ANDAND; end
			"|": begin r.hit = (b == "|"); r.code = P_OROR;   end
			"[": begin r.hit = (b == "["); r.code = P_LBLB;   end
			"]": begin r.hit = (b == "]"); r.code = P_RBRB;   end
			"+": begin r.hit = (b == "+"); r.code = P_INC;    end
			"-": begin r.hit = (b == "-"); r.code = P_DEC;    end
			default: r.hit = 1'b0;
		endcase
		return r;
	endfunction

	function automatic punc_hit_t single_match(input logic [7:0] c);
		punc_hit_t r;
		r.hit  = 1'b1;
		r.code = P_LBRK;
		unique case (c)
			"[": r.code = P_LBRK;
			"]": r.code = P_RBRK;
			"(": r.code = P_LPAR;
			")": r.code = P_RPAR;
			"{": r.code = P_LBRC;
			"}": r.code = P_RBRC;
			"*": r.code = P_STAR;
			"/": r.code = P_SLASH;
			"+": r.code = P_PLUS;
			"-": r.code = P_MINUS;
			"%": r.code = P_PCT;
			"=": r.code = P_ASSIGN;
			";": r.code = P_SEMI;
			"<": r.code = P_LT;
			">": r.code = P_GT;
			"&": r.code = P_AMP;
			"|": r.code = P_BAR;
			",": r.code = P_COMMA;
			default: r.hit = 1'b0;
		endcase
		return r;
	endfunction

endpackage

@@ sv/slx_fifo.sv @@
// Short bundle queue between the lexer front end and the token serialiser.
// Depends on slx_pkg.
module slx_fifo import slx_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  bundle_t push_data,
	input  logic    pop,
	output bundle_t head,
	output q_stat_t stat
);

	localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	bundle_t            mem_q [QDEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]  cnt_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QDEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (pop)
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (push && !pop)
				cnt_q <= cnt_q + QCNT_W'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - QCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	assign head      = mem_q[rd_ptr_q];
	assign stat.full = (cnt_q == QCNT_W'(QDEPTH));
	assign stat.vld  = (cnt_q != '0);

endmodule

@@ sv/slx_front.sv @@
// Lexer front end: takes character beats, runs the scanner state and
// packs the tokens each character raises into one bundle. Depends on slx_pkg.
module slx_front import slx_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       char_valid,
	output logic       char_stall,
	input  char_beat_t char_data,
	input  q_stat_t    q_stat,
	output logic       push,
	output bundle_t    push_data,
	output lex_mode_t  mode
);

	localparam int MAC_W = VAL_W + 4;

	typedef struct packed {
		logic      vld;
		tok_t      tok;
		lex_mode_t mode;
	} flush_t;

	lex_mode_t            mode_q, mode_d;
	logic [7:0]           held_q, held_d;
	logic [VAL_W-1:0]     acc_q, acc_d;
	logic                 ovf_q, ovf_d;
	logic [KW_W-1:0]      kw_q, kw_d;
	logic [POS_WIDTH-1:0] start_q, start_d;
	logic [LEN_W-1:0]     len_q, len_d;
	logic [POS_WIDTH-1:0] pos_q, pos_d;

	logic                 take;
	logic                 consumed;
	logic [CNT_W-1:0]     n;
	bundle_t              bnd;
	punc_hit_t            pm, sm;
	flush_t               fl, fl2;
	logic [MAC_W-1:0]     mac;
	logic [7:0]           c;

	function automatic logic [OUT_POS_W-1:0] pos_out(input logic [POS_WIDTH-1:0] p);
		logic [POS_WIDTH+OUT_POS_W-1:0] w;
		w = {{OUT_POS_W{1'b0}}, p};
		return w[OUT_POS_W-1:0];
	endfunction

	function automatic logic [LEN_W-1:0] grow(input logic [LEN_W-1:0] l);
		return (l < LEN_MAX) ? l + LEN_W'(1) : l;
	endfunction

	function automatic tok_t mk_tok(input logic [3:0] k, input logic [4:0] code,
			input logic [VAL_W-1:0] v, input logic o,
			input logic [POS_WIDTH-1:0] st, input logic [LEN_W-1:0] l);
		tok_t t;
		t.kind      = k;
		t.punc_code = code;
		t.value     = v;
		t.overflow  = o;
		t.start_pos = pos_out(st);
		t.tok_len   = l;
		return t;
	endfunction

	function automatic logic [3:0] ident_kind(input logic [KW_W-1:0] kw,
			input logic [LEN_W-1:0] l);
		logic [3:0] k;
		k = KIND_IDENT;
		if (l == LEN_W'(5) && kw == KW_WHILE)
			k = KIND_WHILE;
		else if (l == LEN_W'(3) && kw == KW_FOR)
			k = KIND_FOR;
		else if (l == LEN_W'(2) && kw == KW_IF)
			k = KIND_IF;
		else if (l == LEN_W'(4) && kw == KW_ELSE)
			k = KIND_ELSE;
		return k;
	endfunction

	// token still pending in the scanner, raised when nothing extends it
	function automatic flush_t flush_tok(input lex_mode_t m, input logic [7:0] held,
			input logic [VAL_W-1:0] acc, input logic ovf, input logic [KW_W-1:0] kw,
			input logic [POS_WIDTH-1:0] st, input logic [LEN_W-1:0] l);
		flush_t    r;
		punc_hit_t s;
		s      = single_match(held);
		r.vld  = 1'b0;
		r.tok  = mk_tok(KIND_PUNC, P_LE, '0, 1'b0, st, l);
		r.mode = m;
		unique case (m)
			MODE_NUM: begin
				r.vld  = 1'b1;
				r.tok  = mk_tok(KIND_NUM, P_LE, acc, ovf, st, l);
				r.mode = MODE_IDLE;
			end
			MODE_IDENT: begin
				r.vld  = 1'b1;
				r.tok  = mk_tok(ident_kind(kw, l), P_LE, '0, 1'b0, st, l);
				r.mode = MODE_IDLE;
			end
			MODE_PUNC: begin
				r.vld = 1'b1;
				if (s.hit) begin
					r.tok  = mk_tok(KIND_PUNC, s.code, '0, 1'b0, st, LEN_W'(1));
					r.mode = MODE_IDLE;
				end else begin
					r.tok  = mk_tok(KIND_ERROR, P_LE, '0, 1'b0, st, LEN_W'(1));
					r.mode = MODE_DISCARD;
				end
			end
			MODE_IDLE:    r.mode = MODE_IDLE;
			MODE_DISCARD: r.mode = MODE_DISCARD;
			default:      r.mode = MODE_IDLE;
		endcase
		return r;
	endfunction

	assign c    = char_data.ch;
	assign take = char_valid && !q_stat.full;

	always_comb begin
		mode_d   = mode_q;
		held_d   = held_q;
		acc_d    = acc_q;
		ovf_d    = ovf_q;
		kw_d     = kw_q;
		start_d  = start_q;
		len_d    = len_q;
		pos_d    = pos_q + POS_WIDTH'(1);
		bnd      = '0;
		n        = '0;
		consumed = 1'b0;
		pm       = pair_match(held_q, c);
		sm       = single_match(c);
		fl       = flush_tok(mode_q, held_q, acc_q, ovf_q, kw_q, start_q, len_q);
		// acc * 10 + digit; digits 0x30..0x39 carry their value in the low nibble
		mac = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + MAC_W'(c[3:0]);

		// continue or close the pending token
		unique case (mode_q)
			MODE_DISCARD: consumed = 1'b1;
			MODE_NUM: begin
				if (is_digit(c)) begin
					if (ovf_q || (mac > {4'b0, NUM_MAX})) begin
						acc_d = NUM_MAX;
						ovf_d = 1'b1;
					end else begin
						acc_d = mac[VAL_W-1:0];
					end
					len_d    = grow(len_q);
					consumed = 1'b1;
				end else begin
					bnd.tok[n] = fl.tok;
					n          = n + CNT_W'(1);
					mode_d     = fl.mode;
				end
			end
			MODE_IDENT: begin
				if (is_word(c)) begin
					if (len_q < LEN_W'(KW_CHARS))
						kw_d = {kw_q[KW_W-9:0], c};
					len_d    = grow(len_q);
					consumed = 1'b1;
				end else begin
					bnd.tok[n] = fl.tok;
					n          = n + CNT_W'(1);
					mode_d     = fl.mode;
				end
			end
			MODE_PUNC: begin
				if (pm.hit) begin
					bnd.tok[n] = mk_tok(KIND_PUNC, pm.code, '0, 1'b0, start_q, LEN_W'(2));
					n          = n + CNT_W'(1);
					mode_d     = MODE_IDLE;
					consumed   = 1'b1;
				end else begin
					bnd.tok[n] = fl.tok;
					n          = n + CNT_W'(1);
					mode_d     = fl.mode;
					consumed   = (fl.mode == MODE_DISCARD);
				end
			end
			default: consumed = 1'b0;
		endcase

		// the character opens something new
		if (!consumed && !is_space(c)) begin
			if (opens_pair(c)) begin
				mode_d  = MODE_PUNC;
				held_d  = c;
				start_d = pos_q;
				len_d   = LEN_W'(1);
			end else if (sm.hit) begin
				bnd.tok[n] = mk_tok(KIND_PUNC, sm.code, '0, 1'b0, pos_q, LEN_W'(1));
				n          = n + CNT_W'(1);
			end else if (is_digit(c)) begin
				mode_d  = MODE_NUM;
				acc_d   = VAL_W'(c[3:0]);
				ovf_d   = 1'b0;
				start_d = pos_q;
				len_d   = LEN_W'(1);
			end else if (is_alpha(c) || c == "_") begin
				mode_d  = MODE_IDENT;
				kw_d    = KW_W'(c);
				start_d = pos_q;
				len_d   = LEN_W'(1);
			end else begin
				bnd.tok[n] = mk_tok(KIND_ERROR, P_LE, '0, 1'b0, pos_q, LEN_W'(1));
				n          = n + CNT_W'(1);
				mode_d     = MODE_DISCARD;
			end
		end

		// end of text: close what is pending, add the end token, start over
		fl2 = flush_tok(mode_d, held_d, acc_d, ovf_d, kw_d, start_d, len_d);
		if (char_data.is_last) begin
			if (mode_d != MODE_DISCARD && fl2.vld) begin
				bnd.tok[n] = fl2.tok;
				n          = n + CNT_W'(1);
			end
			bnd.tok[n] = mk_tok(KIND_END, P_LE, '0, 1'b0, pos_d, '0);
			n          = n + CNT_W'(1);
			mode_d     = MODE_IDLE;
			held_d     = '0;
			acc_d      = '0;
			ovf_d      = 1'b0;
			kw_d       = '0;
			start_d    = '0;
			len_d      = '0;
			pos_d      = '0;
		end
		bnd.cnt = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			held_q  <= '0;
			acc_q   <= '0;
			ovf_q   <= 1'b0;
			kw_q    <= '0;
			start_q <= '0;
			len_q   <= '0;
			pos_q   <= '0;
		end else if (take) begin
			mode_q  <= mode_d;
			held_q  <= held_d;
			acc_q   <= acc_d;
			ovf_q   <= ovf_d;
			kw_q    <= kw_d;
			start_q <= start_d;
			len_q   <= len_d;
			pos_q   <= pos_d;
		end
	end

	assign char_stall = q_stat.full;
	assign push       = take && (n != '0);
	assign push_data  = bnd;
	assign mode       = mode_q;

endmodule

@@ sv/slx_back.sv @@
// Token serialiser: walks the head bundle of the queue one token per beat
// into the output register. Depends on slx_pkg.
module slx_back import slx_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  bundle_t   head,
	input  q_stat_t   q_stat,
	output logic      pop,
	output logic      tok_valid,
	input  logic      tok_stall,
	output tok_beat_t tok_data
);

	logic             out_vld_q;
	tok_beat_t        out_q;
	logic [CNT_W-1:0] idx_q;
	logic             load;
	logic             is_end;
	tok_t             cur;

	assign load   = q_stat.vld && (!out_vld_q || !tok_stall);
	assign cur    = head.tok[idx_q];
	assign is_end = (idx_q == head.cnt - CNT_W'(1));
	assign pop    = load && is_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			idx_q     <= '0;
		end else begin
			if (load)
				out_vld_q <= 1'b1;
			else if (!tok_stall)
				out_vld_q <= 1'b0;
			if (load)
				idx_q <= is_end ? '0 : idx_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.kind        <= cur.kind;
			out_q.punc_code   <= cur.punc_code;
			out_q.value       <= cur.value;
			out_q.overflow    <= cur.overflow;
			out_q.start_pos   <= cur.start_pos;
			out_q.tok_len     <= cur.tok_len;
			out_q.last_of_run <= is_end;
		end
	end

	assign tok_valid = out_vld_q;
	assign tok_data  = out_q;

endmodule

@@ sv/small_language_lexer.sv @@
// Streaming maximal-munch lexer, top level.
// Channels: char_* takes one source byte per beat (ch, is_last); tok_* gives
//   one token per beat (kind, punc_code, value, overflow, start_pos, tok_len,
//   last_of_run). Both use valid/stall; a beat moves when valid is high and
//   stall is low.
// A character raises zero to three tokens; the one flagged last_of_run is the
//   final token of that character. A character with is_last closes any
//   pending token, adds an end token and returns the scanner to offset 0.
// The tokens of a character pass the bundle queue, then the output register.
// Throughput: one character per cycle while each raises at most one token
//   and tok_stall is low; the output register drains one token per cycle
//   while not stalled, so a character that raises more than one token keeps
//   the output busy for each of them. A two-bundle queue between the scanner
//   and the serialiser absorbs this; char_stall rises when it is full.
// A stall on tok_* holds the output beat and, once the queue fills, stalls
//   char_*. Reset (arst_n low) empties the queue and output and clears the
//   scanner to idle at offset 0.
`include "small_language_lexer_defines.svh"
module small_language_lexer import slx_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       char_valid,
	output logic       char_stall,
	input  char_beat_t char_data,
	output logic       tok_valid,
	input  logic       tok_stall,
	output tok_beat_t  tok_data
);

	q_stat_t   qstat;
	logic      push;
	logic      pop;
	bundle_t   push_data;
	bundle_t   head;
	lex_mode_t fmode;

	// scanner: classifies each byte and updates token state
	slx_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_data  (char_data),
		.q_stat     (qstat),
		.push       (push),
		.push_data  (push_data),
		.mode       (fmode)
	);

	// bundles of tokens in flight
	slx_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.stat      (qstat)
	);

	// one token per output beat
	slx_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_stat    (qstat),
		.pop       (pop),
		.tok_valid (tok_valid),
		.tok_stall (tok_stall),
		.tok_data  (tok_data)
	);

	`SLX_ASSERT_IMP(a_no_overrun, clk, arst_n, push, !qstat.full, "bundle pushed into full queue")
	`SLX_ASSERT_IMP(a_end_closes_run, clk, arst_n, tok_valid && tok_data.kind == KIND_END, tok_data.last_of_run, "end token not last of its run")
	`SLX_ASSERT_IMP(a_value_only_num, clk, arst_n, tok_valid && tok_data.kind != KIND_NUM, tok_data.value == '0 && !tok_data.overflow, "value set on non-number token")
	`SLX_ASSERT_NXT(a_last_restarts, clk, arst_n, char_valid && !char_stall && char_data.is_last, fmode == MODE_IDLE, "scanner not idle after last character")

endmodule
